// File: rtl/tos_pkg.sv
// Shared types, widths, codes and helpers for the triangle overlap pipeline.
`default_nettype none

package tos_pkg;

  // Coordinate and arithmetic widths; the normal, product, sum and gap widths follow from COORD_BITS.
  localparam int COORD_BITS     = 32;
  localparam int FIELD_W        = 32;
  localparam int NORM_W         = COORD_BITS + 1;
  localparam int PROD_W         = NORM_W + COORD_BITS;
  localparam int SUM_W          = PROD_W + 1;
  localparam int GAP_W          = SUM_W + 1;
  localparam int BOX_MARGIN_W   = 16;
  localparam int PROJ_MARGIN_W  = 40;
  localparam int CMP_W          = (GAP_W > PROJ_MARGIN_W + 1) ? GAP_W : PROJ_MARGIN_W + 1;
  localparam int BOX_W          = (COORD_BITS + 1 > BOX_MARGIN_W + 1) ?
                                  COORD_BITS + 1 : BOX_MARGIN_W + 1;

  // Pipeline shape.
  localparam int STAGES   = 5;
  localparam int NUM_AXES = 6;
  localparam int NUM_VERT = 6;

  // Register bus.
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_BIT = 3;
  localparam logic REG_BOX_MARGIN  = 1'b0;
  localparam logic REG_PROJ_MARGIN = 1'b1;
  localparam logic [BOX_MARGIN_W-1:0]  BOX_MARGIN_RST  = 16'd1;
  localparam logic [PROJ_MARGIN_W-1:0] PROJ_MARGIN_RST = 40'd1000;

  // Which test separated the pair.
  typedef enum logic [2:0] {
    SEP_NONE,
    SEP_BOX,
    SEP_A0,
    SEP_A1,
    SEP_A2,
    SEP_B0,
    SEP_B1,
    SEP_B2
  } tos_sep_t;

  localparam tos_sep_t AXIS_CODE [NUM_AXES] = '{SEP_A0, SEP_A1, SEP_A2,
                                                SEP_B0, SEP_B1, SEP_B2};

  typedef logic signed [COORD_BITS-1:0] tos_coord_t;
  typedef logic signed [NORM_W-1:0]     tos_norm_t;
  typedef logic signed [PROD_W-1:0]     tos_prod_t;
  typedef logic signed [SUM_W-1:0]      tos_sum_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] first_ax;
    logic signed [FIELD_W-1:0] first_ay;
    logic signed [FIELD_W-1:0] first_bx;
    logic signed [FIELD_W-1:0] first_by;
    logic signed [FIELD_W-1:0] first_cx;
    logic signed [FIELD_W-1:0] first_cy;
    logic signed [FIELD_W-1:0] second_ax;
    logic signed [FIELD_W-1:0] second_ay;
    logic signed [FIELD_W-1:0] second_bx;
    logic signed [FIELD_W-1:0] second_by;
    logic signed [FIELD_W-1:0] second_cx;
    logic signed [FIELD_W-1:0] second_cy;
  } tos_in_t;

  typedef struct packed {
    logic       overlap;
    logic [2:0] separated_by;
  } tos_out_t;

  // Load enables for the stages inside each axis lane.
  typedef struct packed {
    logic ld2;
    logic ld3;
    logic ld4;
    logic ld5;
  } tos_lane_ctl_t;

  // A coordinate is the low COORD_BITS bits of its field, taken as signed.
  function automatic tos_coord_t coord_of(input logic [FIELD_W-1:0] raw);
    return raw[COORD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/tos_cfg.sv
// Register bus slave holding the box and projection margins.
`default_nettype none

module tos_cfg import tos_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [CFG_ADDR_W-1:0]     paddr,
  input  wire logic [CFG_DATA_W-1:0]     pwdata,
  output logic      [CFG_DATA_W-1:0]     prdata,
  output logic                           pready,
  output logic      [BOX_MARGIN_W-1:0]   box_margin,
  output logic      [PROJ_MARGIN_W-1:0]  proj_margin
);

  logic [BOX_MARGIN_W-1:0]  box_margin_r, box_margin_nxt;
  logic [PROJ_MARGIN_W-1:0] proj_margin_r, proj_margin_nxt;
  logic                     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Write decode on the register index bit of the address.
  always_comb begin
    box_margin_nxt  = box_margin_r;
    proj_margin_nxt = proj_margin_r;
    if (wr_en) begin
      case (paddr[CFG_IDX_BIT])
        REG_BOX_MARGIN:  box_margin_nxt  = pwdata[BOX_MARGIN_W-1:0];
        REG_PROJ_MARGIN: proj_margin_nxt = pwdata[PROJ_MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_margin_r  <= BOX_MARGIN_RST;
      proj_margin_r <= PROJ_MARGIN_RST;
    end else begin
      box_margin_r  <= box_margin_nxt;
      proj_margin_r <= proj_margin_nxt;
    end
  end

  // Read mux.
  always_comb begin
    case (paddr[CFG_IDX_BIT])
      REG_BOX_MARGIN:  prdata = CFG_DATA_W'(box_margin_r);
      REG_PROJ_MARGIN: prdata = CFG_DATA_W'(proj_margin_r);
      default:         prdata = '0;
    endcase
  end

  assign box_margin  = box_margin_r;
  assign proj_margin = proj_margin_r;

endmodule

`default_nettype wire

// File: rtl/tos_front.sv
// First pipeline stage: coordinate capture, edge normals and bounding box test.
`default_nettype none

module tos_front import tos_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    ld,
  input  wire tos_in_t                 in_data,
  input  wire logic [BOX_MARGIN_W-1:0] box_margin,
  output tos_coord_t                   x_r [NUM_VERT],
  output tos_coord_t                   y_r [NUM_VERT],
  output tos_norm_t                    nx_r [NUM_AXES],
  output tos_norm_t                    ny_r [NUM_AXES],
  output logic                         box_sep_r
);

  tos_coord_t cx [NUM_VERT];
  tos_coord_t cy [NUM_VERT];
  tos_norm_t  nx [NUM_AXES];
  tos_norm_t  ny [NUM_AXES];
  logic       box_sep;

  function automatic tos_coord_t min3(input tos_coord_t a, input tos_coord_t b,
                                      input tos_coord_t c);
    tos_coord_t m;
    m = (b < a) ? b : a;
    return (c < m) ? c : m;
  endfunction

  function automatic tos_coord_t max3(input tos_coord_t a, input tos_coord_t b,
                                      input tos_coord_t c);
    tos_coord_t m;
    m = (b > a) ? b : a;
    return (c > m) ? c : m;
  endfunction

  // True when the low end of one box lies beyond the other's high end by more than the margin.
  function automatic logic apart(input tos_coord_t lo_v, input tos_coord_t hi_v,
                                 input logic [BOX_MARGIN_W-1:0] m);
    logic signed [BOX_W-1:0] d;
    d = BOX_W'(lo_v) - BOX_W'(hi_v);
    return d > $signed(BOX_W'(m));
  endfunction

  // Vertices 0 to 2 belong to the first triangle, 3 to 5 to the second.
  always_comb begin
    cx[0] = coord_of(in_data.first_ax);
    cy[0] = coord_of(in_data.first_ay);
    cx[1] = coord_of(in_data.first_bx);
    cy[1] = coord_of(in_data.first_by);
    cx[2] = coord_of(in_data.first_cx);
    cy[2] = coord_of(in_data.first_cy);
    cx[3] = coord_of(in_data.second_ax);
    cy[3] = coord_of(in_data.second_ay);
    cx[4] = coord_of(in_data.second_bx);
    cy[4] = coord_of(in_data.second_by);
    cx[5] = coord_of(in_data.second_cx);
    cy[5] = coord_of(in_data.second_cy);
  end

  // Each box is built from its own triangle only.
  always_comb begin
    box_sep = apart(min3(cx[0], cx[1], cx[2]), max3(cx[3], cx[4], cx[5]), box_margin) ||
              apart(min3(cx[3], cx[4], cx[5]), max3(cx[0], cx[1], cx[2]), box_margin) ||
              apart(min3(cy[0], cy[1], cy[2]), max3(cy[3], cy[4], cy[5]), box_margin) ||
              apart(min3(cy[3], cy[4], cy[5]), max3(cy[0], cy[1], cy[2]), box_margin);
  end

  // Edge i of a triangle runs from vertex i to vertex (i+1) mod 3; its normal is
  // (P.y - Q.y, Q.x - P.x), kept unnormalized.
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_norm
    localparam int BASE = (a / 3) * 3;
    localparam int P    = BASE + (a % 3);
    localparam int Q    = BASE + (((a % 3) == 2) ? 0 : (a % 3) + 1);
    assign nx[a] = NORM_W'(cy[P]) - NORM_W'(cy[Q]);
    assign ny[a] = NORM_W'(cx[Q]) - NORM_W'(cx[P]);
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      x_r       <= cx;
      y_r       <= cy;
      nx_r      <= nx;
      ny_r      <= ny;
      box_sep_r <= box_sep;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tos_axis.sv
// One separating axis lane: projection products, sums, intervals and the gap test.
`default_nettype none

module tos_axis import tos_pkg::*; (
  input  wire logic                     clk,
  input  wire tos_lane_ctl_t            ctl,
  input  wire tos_coord_t               x [NUM_VERT],
  input  wire tos_coord_t               y [NUM_VERT],
  input  wire tos_norm_t                nx,
  input  wire tos_norm_t                ny,
  input  wire logic [PROJ_MARGIN_W-1:0] proj_margin,
  output logic                          sep_r
);

  tos_prod_t px_r [NUM_VERT];
  tos_prod_t py_r [NUM_VERT];
  tos_sum_t  d_r  [NUM_VERT];
  tos_sum_t  lo_r [2];
  tos_sum_t  hi_r [2];

  logic signed [CMP_W-1:0] gap_1, gap_2, pm_ext;

  function automatic tos_sum_t min3(input tos_sum_t a, input tos_sum_t b, input tos_sum_t c);
    tos_sum_t m;
    m = (b < a) ? b : a;
    return (c < m) ? c : m;
  endfunction

  function automatic tos_sum_t max3(input tos_sum_t a, input tos_sum_t b, input tos_sum_t c);
    tos_sum_t m;
    m = (b > a) ? b : a;
    return (c > m) ? c : m;
  endfunction

  // Stage two: one multiplier per coordinate, exact at full product width.
  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      for (int k = 0; k < NUM_VERT; k++) begin
        px_r[k] <= nx * x[k];
        py_r[k] <= ny * y[k];
      end
    end
  end

  // Stage three: dot product of the axis with each vertex.
  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      for (int k = 0; k < NUM_VERT; k++) begin
        d_r[k] <= SUM_W'(px_r[k]) + SUM_W'(py_r[k]);
      end
    end
  end

  // Stage four: projected interval of each triangle.
  always_ff @(posedge clk) begin
    if (ctl.ld4) begin
      lo_r[0] <= min3(d_r[0], d_r[1], d_r[2]);
      hi_r[0] <= max3(d_r[0], d_r[1], d_r[2]);
      lo_r[1] <= min3(d_r[3], d_r[4], d_r[5]);
      hi_r[1] <= max3(d_r[3], d_r[4], d_r[5]);
    end
  end

  // Stage five: a gap strictly larger than the margin separates; a degenerate
  // normal gives zero gaps and never does.
  always_comb begin
    gap_1  = CMP_W'(lo_r[0]) - CMP_W'(hi_r[1]);
    gap_2  = CMP_W'(lo_r[1]) - CMP_W'(hi_r[0]);
    pm_ext = $signed(CMP_W'(proj_margin));
  end

  always_ff @(posedge clk) begin
    if (ctl.ld5) begin
      sep_r <= (gap_1 > pm_ext) || (gap_2 > pm_ext);
    end
  end

endmodule

`default_nettype wire

// File: rtl/triangle_overlap_sat.sv
// Top level of the triangle overlap pipeline: stage control, lanes and result coding.
//
//   Channel   Ports                           Moves
//   input     in_valid / in_ready / in_data   one triangle pair per transaction
//   result    out_valid / out_ready / out_data overlap flag and separating test code
//   config    psel penable pwrite paddr ...   margin registers at byte 0 and 8
//
// One transaction per cycle is taken and delivered while out_ready stays high; out_valid
// rises once a pair has passed the five register stages: capture with normals and box
// test, multiplier bank, adders, interval min/max, gap compare.
// Reset clears all stage valid bits and loads margins of 1 and 1000.
// A stage holds while the one after it is full and stalled; empty stages fill
// under a stall, so bubbles collapse and nothing is lost or repeated.
`default_nettype none

module triangle_overlap_sat import tos_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire tos_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output tos_out_t                   out_data,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic [BOX_MARGIN_W-1:0]  box_margin;
  logic [PROJ_MARGIN_W-1:0] proj_margin;

  logic [STAGES:1]   stage_v_r, stage_v_nxt;
  logic [STAGES+1:1] rdy;
  logic [STAGES-1:0] vin;
  logic [STAGES:1]   ld;
  logic [STAGES:2]   box_r;

  tos_coord_t    x_s1 [NUM_VERT];
  tos_coord_t    y_s1 [NUM_VERT];
  tos_norm_t     nx_s1 [NUM_AXES];
  tos_norm_t     ny_s1 [NUM_AXES];
  logic          box_s1;
  tos_lane_ctl_t lane_ctl;
  logic [NUM_AXES-1:0] sep;
  tos_sep_t      code;

  tos_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .box_margin  (box_margin),
    .proj_margin (proj_margin)
  );

  // Stage handshake: a stage loads when its input is valid and it is empty or its successor loads.
  always_comb begin
    vin = {stage_v_r[STAGES-1:1], in_valid};
    rdy[STAGES+1] = out_ready;
    for (int k = STAGES; k >= 1; k--) begin
      rdy[k] = !stage_v_r[k] || rdy[k+1];
    end
    for (int k = 1; k <= STAGES; k++) begin
      ld[k]          = rdy[k] & vin[k-1];
      stage_v_nxt[k] = rdy[k] ? vin[k-1] : stage_v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= '0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
  end

  assign in_ready  = rdy[1];
  assign out_valid = stage_v_r[STAGES];

  tos_front u_front (
    .clk        (clk),
    .ld         (ld[1]),
    .in_data    (in_data),
    .box_margin (box_margin),
    .x_r        (x_s1),
    .y_r        (y_s1),
    .nx_r       (nx_s1),
    .ny_r       (ny_s1),
    .box_sep_r  (box_s1)
  );

  // The box test result rides alongside the lanes.
  always_ff @(posedge clk) begin
    if (ld[2]) begin
      box_r[2] <= box_s1;
    end
    for (int k = 3; k <= STAGES; k++) begin
      if (ld[k]) begin
        box_r[k] <= box_r[k-1];
      end
    end
  end

  assign lane_ctl = '{ld2: ld[2], ld3: ld[3], ld4: ld[4], ld5: ld[5]};

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    tos_axis u_axis (
      .clk         (clk),
      .ctl         (lane_ctl),
      .x           (x_s1),
      .y           (y_s1),
      .nx          (nx_s1[a]),
      .ny          (ny_s1[a]),
      .proj_margin (proj_margin),
      .sep_r       (sep[a])
    );
  end

  // The box test wins, then the lowest numbered axis that separates.
  always_comb begin
    code = SEP_NONE;
    for (int a = NUM_AXES - 1; a >= 0; a--) begin
      if (sep[a]) begin
        code = AXIS_CODE[a];
      end
    end
    if (box_r[STAGES]) begin
      code = SEP_BOX;
    end
  end

  assign out_data.separated_by = code;
  assign out_data.overlap      = (code == SEP_NONE);

`ifndef SYNTHESIS
  // Reset empties the whole pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> (stage_v_r == '0))
    else $error("pipeline not empty after reset");

  // An accepted transaction occupies the first stage next cycle.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> stage_v_r[1])
    else $error("accepted transaction did not enter stage one");

  // A stage blocked by a full successor keeps its item and its box flag.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_v_r[STAGES-1] && !rdy[STAGES]) |=>
      (stage_v_r[STAGES-1] && $stable(box_r[STAGES-1])))
    else $error("stalled stage lost its item");

  // The first stage never loads while the second is full and stalled.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_v_r[1] && !rdy[2]) |-> !in_ready)
    else $error("input taken while stage one is blocked");
`endif

endmodule

`default_nettype wire

// File: sim/tb_triangle_overlap_sat.sv
`timescale 1ns / 100ps
// Self-checking testbench for the triangle overlap pipeline with its margin registers.

module tb_triangle_overlap_sat;
  import tos_pkg::*;

  // Exact arithmetic width for projections; every intermediate fits with room to spare.
  typedef logic signed [79:0] wide_int_t;

  localparam int C_MIN       = 32'sh8000_0000;
  localparam int C_MAX       = 32'sh7fff_ffff;
  localparam int STALL_LIMIT = 2000;
  localparam int SEGMENT_LEN = 450;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  tos_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  tos_out_t              out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Shadow copies of the margin registers.
  logic [BOX_MARGIN_W-1:0]  box_margin_q = BOX_MARGIN_RST;
  logic [PROJ_MARGIN_W-1:0] proj_margin_q = PROJ_MARGIN_RST;

  tos_out_t pending_verdicts [$];
  int       error_count = 0;
  int       quiet_cycles = 0;
  int       in_idle_pct = 12;
  int       out_idle_pct = 12;

  triangle_overlap_sat dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Computes which test separates the pair, or SEP_NONE when they overlap.
  function automatic tos_sep_t find_separation(input tos_in_t p,
                                               input logic [BOX_MARGIN_W-1:0] bm_in,
                                               input logic [PROJ_MARGIN_W-1:0] pm_in);
    wide_int_t crd [2][2][3];
    wide_int_t bmin [2][2];
    wide_int_t bmax [2][2];
    wide_int_t lo [2];
    wide_int_t hi [2];
    wide_int_t bm, pm, nx, ny, d;
    int s, k, v, t, i, j;
    crd[0][0][0] = coord_of(p.first_ax);
    crd[0][1][0] = coord_of(p.first_ay);
    crd[0][0][1] = coord_of(p.first_bx);
    crd[0][1][1] = coord_of(p.first_by);
    crd[0][0][2] = coord_of(p.first_cx);
    crd[0][1][2] = coord_of(p.first_cy);
    crd[1][0][0] = coord_of(p.second_ax);
    crd[1][1][0] = coord_of(p.second_ay);
    crd[1][0][1] = coord_of(p.second_bx);
    crd[1][1][1] = coord_of(p.second_by);
    crd[1][0][2] = coord_of(p.second_cx);
    crd[1][1][2] = coord_of(p.second_cy);
    bm = bm_in;
    pm = pm_in;

    // Bounding boxes of each triangle, per dimension.
    for (s = 0; s < 2; s++) begin
      for (k = 0; k < 2; k++) begin
        bmin[s][k] = crd[s][k][0];
        bmax[s][k] = crd[s][k][0];
        for (v = 1; v < 3; v++) begin
          if (crd[s][k][v] < bmin[s][k]) bmin[s][k] = crd[s][k][v];
          if (crd[s][k][v] > bmax[s][k]) bmax[s][k] = crd[s][k][v];
        end
      end
    end
    for (k = 0; k < 2; k++) begin
      if (bmin[0][k] - bmax[1][k] > bm || bmin[1][k] - bmax[0][k] > bm) return SEP_BOX;
    end

    // Edge normals of the first triangle, then the second, in edge order.
    for (t = 0; t < 2; t++) begin
      for (i = 0; i < 3; i++) begin
        j = (i + 1) % 3;
        nx = crd[t][1][i] - crd[t][1][j];
        ny = crd[t][0][j] - crd[t][0][i];
        for (s = 0; s < 2; s++) begin
          for (v = 0; v < 3; v++) begin
            d = nx * crd[s][0][v] + ny * crd[s][1][v];
            if (v == 0 || d < lo[s]) lo[s] = d;
            if (v == 0 || d > hi[s]) hi[s] = d;
          end
        end
        if (lo[0] - hi[1] > pm || lo[1] - hi[0] > pm) return AXIS_CODE[3 * t + i];
      end
    end
    return SEP_NONE;
  endfunction

  function automatic tos_in_t pair_of(input int fax, fay, fbx, fby, fcx, fcy,
                                      input int sax, say, sbx, sby, scx, scy);
    tos_in_t p;
    p.first_ax  = fax;
    p.first_ay  = fay;
    p.first_bx  = fbx;
    p.first_by  = fby;
    p.first_cx  = fcx;
    p.first_cy  = fcy;
    p.second_ax = sax;
    p.second_ay = say;
    p.second_bx = sbx;
    p.second_by = sby;
    p.second_cx = scx;
    p.second_cy = scy;
    return p;
  endfunction

  // Signed random offset in [-2^sh, 2^sh).
  function automatic int spread(input int sh);
    int r;
    r = $urandom;
    return r >>> (31 - sh);
  endfunction

  // Mostly pairs clustered at a random scale so all tests get reached; some pure noise.
  function automatic tos_in_t random_pair();
    logic [31:0] v [12];
    int sh, cx, cy, ox, oy, k;
    if ($urandom_range(0, 9) == 0) begin
      for (k = 0; k < 12; k++) v[k] = $urandom;
    end else begin
      case ($urandom_range(0, 7))
        0, 1, 2, 3: sh = $urandom_range(3, 8);
        4, 5:       sh = $urandom_range(9, 16);
        6:          sh = $urandom_range(17, 30);
        default:    sh = 31;
      endcase
      cx = $urandom;
      cy = $urandom;
      ox = spread(sh);
      oy = spread(sh);
      for (k = 0; k < 12; k++) begin
        v[k] = ((k % 2) ? cy : cx) + ((k >= 6) ? ((k % 2) ? oy : ox) : 0) + spread(sh);
      end
      // Occasionally collapse an edge to a point.
      if ($urandom_range(0, 9) == 0) begin
        v[2] = v[0];
        v[3] = v[1];
      end
      if ($urandom_range(0, 19) == 0) begin
        v[10] = v[8];
        v[11] = v[9];
      end
    end
    return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10], v[11]};
  endfunction

  // Presents one pair after a random gap and records its verdict once accepted.
  task automatic send_pair(input tos_in_t p);
    tos_sep_t code;
    tos_out_t verdict;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
    code = find_separation(p, box_margin_q, proj_margin_q);
    verdict.overlap      = (code == SEP_NONE);
    verdict.separated_by = code;
    pending_verdicts.insert(pending_verdicts.size(), verdict);
  endtask

  // Stops sending and waits until every outstanding verdict has come back.
  task automatic wait_for_verdicts();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx) << CFG_IDX_BIT;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_BOX_MARGIN) box_margin_q = value[BOX_MARGIN_W-1:0];
    else proj_margin_q = value[PROJ_MARGIN_W-1:0];
  endtask

  // Reads a register back and compares it with the shadow copy.
  task automatic check_register(input logic idx);
    logic [CFG_DATA_W-1:0] got, want;
    want = (idx == REG_BOX_MARGIN) ? CFG_DATA_W'(box_margin_q) : CFG_DATA_W'(proj_margin_q);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_ADDR_W'(idx) << CFG_IDX_BIT;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      $display("%0t: register %0d readback expected %0h actual %0h", $time, idx, want, got);
      error_count++;
    end
  endtask

  task automatic set_margins(input logic [BOX_MARGIN_W-1:0] bm,
                             input logic [PROJ_MARGIN_W-1:0] pm);
    cfg_write(REG_BOX_MARGIN, CFG_DATA_W'(bm));
    cfg_write(REG_PROJ_MARGIN, CFG_DATA_W'(pm));
    check_register(REG_BOX_MARGIN);
    check_register(REG_PROJ_MARGIN);
  endtask

  // Both registers must come out of reset at their documented values.
  task automatic test_reset_values();
    check_register(REG_BOX_MARGIN);
    check_register(REG_PROJ_MARGIN);
  endtask

  // Hand-built pairs at the reset margins: every separating test, degenerate shapes, extremes.
  task automatic test_directed_pairs();
    send_pair(pair_of(0, 0, 100, 0, 0, 100, 0, 0, 100, 0, 0, 100));
    send_pair(pair_of(0, 0, 100, 0, 0, 100, 1000, 0, 1100, 0, 1000, 100));
    send_pair(pair_of(0, 0, 100, 0, 0, 100, 0, 1000, 100, 1000, 0, 1100));
    send_pair(pair_of(0, 0, 100, 0, 0, 100, -1000, 0, -900, 0, -1000, 100));
    // Box gap equal to the margin, then one past it.
    send_pair(pair_of(0, 0, 100, 0, 0, 100, 101, 0, 201, 0, 101, 100));
    send_pair(pair_of(0, 0, 100, 0, 0, 100, 102, 0, 202, 0, 102, 100));
    // Hypotenuse of the first triangle separates; rotation picks the edge.
    send_pair(pair_of(0, 0, 100, 0, 0, 100, 100, 100, 60, 100, 100, 60));
    send_pair(pair_of(100, 0, 0, 100, 0, 0, 100, 100, 60, 100, 100, 60));
    send_pair(pair_of(0, 100, 0, 0, 100, 0, 100, 100, 60, 100, 100, 60));
    // A point has only zero normals, so the second triangle's edges decide.
    send_pair(pair_of(80, 80, 80, 80, 80, 80, 0, 0, 100, 0, 0, 100));
    send_pair(pair_of(80, 80, 80, 80, 80, 80, 100, 0, 0, 100, 0, 0));
    send_pair(pair_of(80, 80, 80, 80, 80, 80, 0, 100, 0, 0, 100, 0));
    send_pair(pair_of(0, 0, 100, 0, 0, 100, 10, 10, 50, 50, 30, 30));
    // Projected gap exactly equal to the margin.
    send_pair(pair_of(0, 0, 100, 0, 0, 100, 60, 50, 100, 60, 60, 100));
    // Coordinate extremes.
    send_pair(pair_of(C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX,
                      C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX));
    send_pair(pair_of(C_MIN, C_MIN, C_MIN + 1, C_MIN, C_MIN, C_MIN + 1,
                      C_MAX, C_MAX, C_MAX - 1, C_MAX, C_MAX, C_MAX - 1));
    send_pair(pair_of(C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX,
                      C_MAX, C_MAX, C_MAX - 1, C_MAX, C_MAX, C_MAX - 1));
    send_pair(pair_of(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                      C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
    send_pair(pair_of(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                      C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
    send_pair(pair_of(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX,
                      C_MIN, C_MIN, C_MIN, C_MIN + 1, C_MIN + 1, C_MIN));
  endtask

  // Margins at zero, at full scale and around a known projected gap.
  task automatic test_margin_settings();
    wait_for_verdicts();
    set_margins('0, '0);
    send_pair(pair_of(0, 0, 100, 0, 0, 100, 100, 0, 200, 0, 100, 100));
    send_pair(pair_of(0, 0, 100, 0, 0, 100, 101, 0, 201, 0, 101, 100));
    send_pair(pair_of(0, 0, 100, 0, 0, 100, 60, 50, 100, 60, 60, 100));
    send_pair(pair_of(0, 0, 100, 0, 0, 100, 0, 0, 100, 0, 0, 100));
    wait_for_verdicts();
    set_margins('1, '1);
    send_pair(pair_of(0, 0, 100, 0, 0, 100, 65635, 0, 65735, 0, 65635, 100));
    send_pair(pair_of(0, 0, 100, 0, 0, 100, 65636, 0, 65736, 0, 65636, 100));
    send_pair(pair_of(0, 0, 100, 0, 0, 100, 100, 100, 60, 100, 100, 60));
    wait_for_verdicts();
    set_margins(BOX_MARGIN_RST, 40'd999);
    send_pair(pair_of(0, 0, 100, 0, 0, 100, 60, 50, 100, 60, 60, 100));
  endtask

  // Random pairs in segments, each with its own margins; one segment also runs without idling.
  task automatic test_random_pairs();
    logic [63:0] raw;
    int seg, n;
    for (seg = 0; seg < 4; seg++) begin
      wait_for_verdicts();
      raw = {$urandom, $urandom};
      case (seg)
        0: set_margins(BOX_MARGIN_RST, PROJ_MARGIN_RST);
        1: set_margins(16'($urandom_range(0, 65535) >> $urandom_range(0, 15)),
                       40'(raw >> $urandom_range(24, 63)));
        2: set_margins(16'($urandom_range(0, 4)), 40'($urandom_range(0, 2000)));
        default: set_margins(16'($urandom_range(0, 65535)), 40'(raw >> 24));
      endcase
      // The second segment runs with no idling on either side.
      in_idle_pct  = (seg == 1) ? 0 : 12;
      out_idle_pct = (seg == 1) ? 0 : 12;
      for (n = 0; n < SEGMENT_LEN; n++) begin
        if (seg == 3 && n == SEGMENT_LEN / 2) wait_for_verdicts();
        send_pair(random_pair());
      end
    end
    in_idle_pct  = 12;
    out_idle_pct = 12;
  endtask

  // Result side stalls at random.
  always @(negedge clk) begin
    out_ready <= !($urandom_range(0, 99) < out_idle_pct);
  end

  // Compares every result transaction with the oldest outstanding verdict.
  always @(posedge clk) begin : verdict_check
    tos_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result expected none actual overlap=%0d separated_by=%0d",
                 $time, out_data.overlap, out_data.separated_by);
        error_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_data.overlap !== want.overlap) begin
          $display("%0t: overlap expected %0d actual %0d",
                   $time, want.overlap, out_data.overlap);
          error_count++;
        end
        if (out_data.separated_by !== want.separated_by) begin
          $display("%0t: separated_by expected %0d actual %0d",
                   $time, want.separated_by, out_data.separated_by);
          error_count++;
        end
      end
    end
  end

  // Ends the run if no transaction moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_verdicts.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_directed_pairs();
    test_margin_settings();
    test_random_pairs();
    wait_for_verdicts();
    repeat (4 * STAGES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
